// ===== hdl/hbpe_pkg.sv =====
// Shared types and constants of the Huffman bit-packing encoder.
package hbpe_pkg;

  // Field widths of the transactions.
  localparam int OPERATION_W   = 2;
  localparam int SYMBOL_W      = 7;
  localparam int CODE_VALUE_W  = 31;
  localparam int CODE_LENGTH_W = 5;
  localparam int BYTE_BITS     = 8;

  // Defaults of the top-level parameters.
  localparam int SYMBOL_COUNT_DEF  = 128;
  localparam int MAX_CODE_BITS_DEF = 31;

  // Bit accumulator of the packer: seven pending bits plus one whole code.
  localparam int ACC_W     = CODE_VALUE_W + BYTE_BITS - 1;
  localparam int ACC_CNT_W = $clog2(ACC_W + 1);

  // Job queue between the front end and the packer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes.
  typedef enum logic [OPERATION_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } hbpe_op_t;

  // Input transaction.
  typedef struct packed {
    logic [OPERATION_W-1:0]   operation;
    logic [SYMBOL_W-1:0]      symbol;
    logic [CODE_VALUE_W-1:0]  code_value;
    logic [CODE_LENGTH_W-1:0] code_length;
  } hbpe_in_t;

  // Result transaction.
  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;
  } hbpe_out_t;

  // Job handed from the front end to the packer.
  typedef struct packed {
    logic                     fin;
    logic [CODE_LENGTH_W-1:0] len;
    logic [CODE_VALUE_W-1:0]  val;
  } hbpe_job_t;

endpackage

// ===== hdl/hbpe_front.sv =====
// Front end: classifies input transactions, owns the code table, issues packer jobs.
module hbpe_front import hbpe_pkg::*; #(
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  hbpe_in_t  item,
  output logic      job_valid,
  output hbpe_job_t job
);

  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam int VAL_W = (MAX_CODE_BITS < CODE_VALUE_W) ? MAX_CODE_BITS : CODE_VALUE_W;
  localparam int ENT_W = VAL_W + CODE_LENGTH_W;
  localparam logic [CODE_LENGTH_W-1:0] LEN_MAX = CODE_LENGTH_W'(VAL_W);

  logic [ENT_W-1:0]         table_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]  entry_valid_r;
  logic [ENT_W-1:0]         rd_data_r;
  logic                     hit_r;
  logic                     s1_valid_r;
  logic                     s1_fin_r;

  logic                     in_range;
  logic                     is_load;
  logic                     is_job;
  logic                     is_finish;
  logic [IDX_W-1:0]         wr_idx;
  logic [IDX_W-1:0]         rd_idx;
  logic [CODE_LENGTH_W-1:0] len_sat;
  logic [CODE_VALUE_W-1:0]  val_masked;

  // Decode the transaction and prepare the table entry.
  always_comb begin
    in_range   = ({2'b00, item.symbol} < 9'(SYMBOL_COUNT));
    is_finish  = (item.operation == OP_FINISH);
    is_load    = accept && (item.operation == OP_LOAD) && in_range;
    is_job     = accept && ((item.operation == OP_ENCODE) || is_finish);
    wr_idx     = IDX_W'(item.symbol);
    rd_idx     = is_finish ? '0 : IDX_W'(item.symbol);
    len_sat    = (item.code_length > LEN_MAX) ? LEN_MAX : item.code_length;
    val_masked = item.code_value & ~({CODE_VALUE_W{1'b1}} << len_sat);
  end

  // Code table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (is_load) begin
      table_mem[wr_idx] <= {len_sat, val_masked[VAL_W-1:0]};
    end
    rd_data_r <= table_mem[rd_idx];
  end

  // Entry valid bits and the job stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      s1_valid_r    <= 1'b0;
      s1_fin_r      <= 1'b0;
      hit_r         <= 1'b0;
    end else begin
      if (is_load) begin
        entry_valid_r[wr_idx] <= 1'b1;
      end
      s1_valid_r <= is_job;
      s1_fin_r   <= is_finish;
      hit_r      <= entry_valid_r[rd_idx] && (is_finish || in_range);
    end
  end

  // An entry that was never loaded, or a symbol beyond the table, is an empty code.
  always_comb begin
    job_valid = s1_valid_r;
    job.fin   = s1_fin_r;
    job.len   = hit_r ? rd_data_r[ENT_W-1:VAL_W] : '0;
    job.val   = hit_r ? CODE_VALUE_W'(rd_data_r[VAL_W-1:0]) : '0;
  end

endmodule

// ===== hdl/hbpe_fifo.sv =====
// Short job queue between the front end and the packer.
module hbpe_fifo import hbpe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  hbpe_job_t              wdata,
  input  logic                   pop,
  output hbpe_job_t              rdata,
  output logic                   empty,
  output logic [QUEUE_CNT_W-1:0] count
);

  hbpe_job_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign rdata = slots[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r < QUEUE_CNT_W'(QUEUE_DEPTH)))
    else $error("job queue overflow");

  // The packer never takes from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("job queue underflow");

endmodule

// ===== hdl/hbpe_back.sv =====
// Packer: appends code bits to the bit accumulator and emits bytes through an output register.
module hbpe_back import hbpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hbpe_job_t job,
  input  logic      job_empty,
  output logic      job_pop,
  input  logic      pop,
  output logic      empty,
  output hbpe_out_t out_item
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam logic [ACC_CNT_W-1:0] CNT_BYTE = ACC_CNT_W'(BYTE_BITS);
  localparam logic [ACC_CNT_W-1:0] CNT_TWO  = ACC_CNT_W'(2 * BYTE_BITS);

  state_t                 state_r,     state_nxt;
  logic [ACC_W-1:0]       acc_r,       acc_nxt;
  logic [ACC_CNT_W-1:0]   cnt_r,       cnt_nxt;
  logic                   fin_r,       fin_nxt;
  logic                   out_valid_r, out_valid_nxt;
  hbpe_out_t              out_r,       out_nxt;

  logic                   out_free;
  logic [ACC_W-1:0]       full_shift;
  logic [ACC_W-1:0]       part_shift;

  // Byte views of the accumulator: the oldest whole byte, and the padded remainder.
  always_comb begin
    full_shift = acc_r >> (cnt_r - CNT_BYTE);
    part_shift = acc_r << (CNT_BYTE - cnt_r);
    out_free   = !out_valid_r || pop;
  end

  // Sequencer: take a job, emit one byte a cycle while the output register is free, close the job.
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    job_pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          acc_nxt   = (acc_r << job.len) | ACC_W'(job.val);
          cnt_nxt   = cnt_r + ACC_CNT_W'(job.len);
          fin_nxt   = job.fin;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        priority if (cnt_r >= CNT_BYTE) begin
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_nxt.out_byte = full_shift[BYTE_BITS-1:0];
            out_nxt.last     = fin_r ? (cnt_r == CNT_BYTE) : (cnt_r < CNT_TWO);
            cnt_nxt          = cnt_r - CNT_BYTE;
          end
        end else if (fin_r && (cnt_r != '0)) begin
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_nxt.out_byte = part_shift[BYTE_BITS-1:0];
            out_nxt.last     = 1'b1;
            cnt_nxt          = '0;
            state_nxt        = ST_IDLE;
          end
        end else begin
          if (fin_r) begin
            cnt_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, accumulator and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

  // Between jobs the accumulator never holds a whole byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r < CNT_BYTE))
    else $error("whole byte left pending between jobs");

  // A finish job leaves the bit buffer clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && fin_r && state_nxt == ST_IDLE) |=> (cnt_r == '0))
    else $error("bit buffer not cleared after finish");

endmodule

// ===== hdl/huffman_bit_packing_encoder_core.sv =====
// Top level of the Huffman bit-packing encoder: front end, job queue and packer.
//
//   Channel  Ports                        Transaction taken when
//   input    push, full, in_item          push high and full low
//   result   empty, pop, out_item         pop high and empty low
//
// A load is handled in the front end alone and issues no packer job; the code table read is registered.
// An encode or finish job is taken in the packer's idle state and emits its bytes (0 to 5)
// in the run state, one byte per cycle through the output register while that register is
// free; a finish that ends on a padded partial byte returns to idle with that last byte.
// Reset clears the table valid bits, the bit buffer, the job queue and the output.
// The four-entry job queue lets the front end keep accepting while the packer
// or the result side stalls; full rises when the queue and the read stage are taken.
module huffman_bit_packing_encoder_core import hbpe_pkg::*; #(
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  hbpe_in_t  in_item,
  output logic      empty,
  input  logic      pop,
  output hbpe_out_t out_item
);

  logic                   accept;
  logic                   job_valid;
  hbpe_job_t              job_in;
  hbpe_job_t              job_out;
  logic                   job_empty;
  logic                   job_pop;
  logic [QUEUE_CNT_W-1:0] job_count;

  // Room must remain for the job still in the table read stage.
  assign full   = ({1'b0, job_count} + (QUEUE_CNT_W + 1)'(job_valid))
                  >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
  assign accept = push && !full;

  hbpe_front #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .job_valid (job_valid),
    .job       (job_in)
  );

  hbpe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_valid),
    .wdata (job_in),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty),
    .count (job_count)
  );

  hbpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule
